// File: design/c3rgb_pkg.sv
// shared types and constants for the 3x3 rgb convolution block
// no dependencies
package c3rgb_pkg;
  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned PIX_W = 24;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned KROW_W = 48;
  localparam int unsigned COL_W = 11;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned FW_W = 12;
  localparam int unsigned CHAN_MAX = 255;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } reg_idx_t;

  // one classified beat handed from the front to the back
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic [PIX_W-1:0]      px;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic                  interior;
    logic                  border;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] rgb;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;
endpackage

// File: design/conv3x3_rgb_border_passthrough_unit.sv
// top level of the 3x3 rgb convolution with border pass-through
// uses c3rgb_pkg, c3rgb_front, c3rgb_fifo, c3rgb_back
//
// Usage: pixels enter on s_axis in raster order, one beat per clock at full
// rate. Each result leaves on m_axis with its column and row in tdata and
// last_of_run in tlast. A border pixel yields one result at once; an interior
// pixel's filtered result leaves when its lower-right neighbour is taken, and
// comes before that neighbour's own border result when both are due.
// From input beat to result the path runs through the front (line store read
// and window shift), the queue, multiply, sum and round, and the output
// register. Throughput is one pixel per clock, except that a beat giving two
// results holds the output for both. Registers are written through
// cfg_we/cfg_index/cfg_data by the user only while idle; the block has no
// check for it. Writing width or height restarts the frame at column and row
// zero. Reset clears counters, window, queue and pipeline; line stores are
// not cleared. When m_axis_tready is low, the output register holds its beat
// and back-pressure reaches s_axis_tready after the queue fills.
module conv3x3_rgb_border_passthrough_unit #(
  parameter int COEFF_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // red, green, blue, column, row, zero pad
  output logic        m_axis_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  logic [c3rgb_pkg::FW_W-1:0] frame_width;
  logic [c3rgb_pkg::ROW_W-1:0] frame_height;
  logic [2:0][c3rgb_pkg::KROW_W-1:0] kernel;
  logic restart;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  c3rgb_pkg::job_t fj, bj;
  c3rgb_pkg::res_t res;

  assign restart = cfg_we && (cfg_index == c3rgb_pkg::REG_WIDTH
                              || cfg_index == c3rgb_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 12'd640;
      frame_height <= 16'd480;
      kernel[0] <= '0;
      kernel[1] <= 48'(1 << COEFF_FRAC_BITS) << 16;
      kernel[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        c3rgb_pkg::REG_WIDTH:  frame_width <= cfg_data[11:0];
        c3rgb_pkg::REG_HEIGHT: frame_height <= cfg_data[15:0];
        c3rgb_pkg::REG_KTOP:   kernel[0] <= cfg_data;
        c3rgb_pkg::REG_KMID:   kernel[1] <= cfg_data;
        c3rgb_pkg::REG_KBOT:   kernel[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  c3rgb_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_px({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .restart, .frame_width, .frame_height,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

  c3rgb_fifo u_fifo (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj));

  c3rgb_back #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .kernel, .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res);

  assign m_axis_tdata = {5'd0, res.row, res.col, res.rgb[7:0], res.rgb[15:8],
                         res.rgb[23:16]};
  assign m_axis_tlast = res.last;
endmodule

// File: design/c3rgb_ram.sv
// generic single write, single registered read ram
// no dependencies
module c3rgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: design/c3rgb_front.sv
// front: position counters, line stores, 3x3 window and classification
// uses c3rgb_pkg and c3rgb_ram
module c3rgb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [c3rgb_pkg::PIX_W-1:0]   in_px,
  input  logic                          restart,
  input  logic [c3rgb_pkg::FW_W-1:0]    frame_width,
  input  logic [c3rgb_pkg::ROW_W-1:0]   frame_height,
  output logic                          job_valid,
  input  logic                          job_ready,
  output c3rgb_pkg::job_t               job
);
  localparam int AW = $clog2(c3rgb_pkg::MAX_WIDTH);
  localparam int EW = $clog2(c3rgb_pkg::MAX_WIDTH + 1);

  logic [c3rgb_pkg::COL_W-1:0] col;
  logic [c3rgb_pkg::ROW_W-1:0] row;
  logic [8:0][c3rgb_pkg::PIX_W-1:0] win;
  logic [EW-1:0] w_eff;
  logic [c3rgb_pkg::ROW_W-1:0] h_eff;
  logic acc;
  logic [AW-1:0] idx;
  logic [c3rgb_pkg::PIX_W-1:0] old_rd, new_rd;

  // stage 1 holds the beat while the line stores are read
  logic s1_valid;
  logic [c3rgb_pkg::PIX_W-1:0] s1_px;
  logic [c3rgb_pkg::COL_W-1:0] s1_col;
  logic [c3rgb_pkg::ROW_W-1:0] s1_row;
  logic s1_border;
  logic [AW-1:0] s1_idx;
  logic adv;

  // classified beat fields beside the window
  logic [c3rgb_pkg::PIX_W-1:0] j_px;
  logic [c3rgb_pkg::COL_W-1:0] j_col;
  logic [c3rgb_pkg::ROW_W-1:0] j_row;
  logic j_interior, j_border;

  always_comb begin
    if (frame_width == '0) w_eff = EW'(1);
    else if ({1'b0, frame_width} > 13'(c3rgb_pkg::MAX_WIDTH)) w_eff = EW'(c3rgb_pkg::MAX_WIDTH);
    else w_eff = EW'(frame_width);
    h_eff = (frame_height == '0) ? c3rgb_pkg::ROW_W'(1) : frame_height;
  end

  assign adv = !job_valid || job_ready;
  assign in_ready = adv;
  assign acc = in_valid && in_ready;
  assign idx = AW'(col);

  c3rgb_ram #(.WIDTH(c3rgb_pkg::PIX_W), .DEPTH(c3rgb_pkg::MAX_WIDTH)) u_old (
    .clk, .we(s1_valid && adv), .waddr(s1_idx), .wdata(new_rd),
    .re(acc), .raddr(idx), .rdata(old_rd));
  c3rgb_ram #(.WIDTH(c3rgb_pkg::PIX_W), .DEPTH(c3rgb_pkg::MAX_WIDTH)) u_new (
    .clk, .we(s1_valid && adv), .waddr(s1_idx), .wdata(s1_px),
    .re(acc), .raddr(idx), .rdata(new_rd));

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (32'(col) + 1 >= 32'(w_eff)) begin
        col <= '0;
        row <= (32'(row) + 1 >= 32'(h_eff)) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      job_valid <= 1'b0;
      win <= '0;
    end else if (adv) begin
      s1_valid <= acc;
      job_valid <= s1_valid;
      if (s1_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3] <= win[i*3+1];
          win[i*3+1] <= win[i*3+2];
        end
        win[2] <= old_rd;
        win[5] <= new_rd;
        win[8] <= s1_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc) begin
        s1_px <= in_px;
        s1_col <= col;
        s1_row <= row;
        s1_idx <= idx;
        s1_border <= (row == '0) || (col == '0) || (32'(row) + 1 == 32'(h_eff))
                     || (32'(col) + 1 == 32'(w_eff));
      end
      if (s1_valid) begin
        j_px <= s1_px;
        j_col <= s1_col;
        j_row <= s1_row;
        j_interior <= (s1_col >= 2) && (s1_row >= 2);
        j_border <= s1_border;
      end
    end
  end

  assign job = {win, j_px, j_col, j_row, j_interior, j_border};
endmodule

// File: design/c3rgb_fifo.sv
// short queue of classified beats between front and back
// uses c3rgb_pkg
module c3rgb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  c3rgb_pkg::job_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output c3rgb_pkg::job_t rd_data
);
  c3rgb_pkg::job_t buf_q [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = buf_q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) buf_q[wp] <= wr_data;
  end
endmodule

// File: design/c3rgb_back.sv
// back: multiply stage, sum, round and clamp, then result emission
// uses c3rgb_pkg
module c3rgb_back #(
  parameter int COEFF_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  output logic                            job_ready,
  input  c3rgb_pkg::job_t                 job,
  input  logic [2:0][c3rgb_pkg::KROW_W-1:0] kernel,
  output logic                            res_valid,
  input  logic                            res_ready,
  output c3rgb_pkg::res_t                 res
);
  typedef logic signed [24:0] prod_t;
  typedef logic signed [29:0] acc_t;

  // stage a: nine products per channel
  logic a_valid;
  c3rgb_pkg::job_t a_job;
  prod_t a_prod [3][9];
  // stage b: filtered pixel ready
  logic b_valid;
  c3rgb_pkg::job_t b_job;
  logic [c3rgb_pkg::PIX_W-1:0] b_rgb;
  logic b_phase; // interior already sent, border pending
  logic stall_b, adv_a, b_done;
  logic [c3rgb_pkg::PIX_W-1:0] filt;

  function automatic logic [7:0] finish(input acc_t s);
    acc_t v;
    begin
      v = (s + acc_t'(1 << (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
      if (s <= 0) finish = 8'd0;
      else if (v > acc_t'(c3rgb_pkg::CHAN_MAX)) finish = 8'(c3rgb_pkg::CHAN_MAX);
      else finish = v[7:0];
    end
  endfunction

  always_comb begin
    acc_t s;
    for (int ch = 0; ch < 3; ch++) begin
      s = '0;
      for (int k = 0; k < 9; k++) s = s + acc_t'(a_prod[ch][k]);
      filt[16 - ch*8 +: 8] = finish(s);
    end
  end

  // a beat holds stage b for both results when both are due
  assign b_done = !b_valid || !(b_job.interior && b_job.border && !b_phase);
  assign stall_b = b_valid && !(res_ready || !res_valid);
  assign adv_a = !b_valid || (!stall_b && b_done);
  assign job_ready = !a_valid || adv_a;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (job_ready) a_valid <= job_valid;
    if (job_ready && job_valid) begin
      a_job <= job;
      for (int ch = 0; ch < 3; ch++)
        for (int k = 0; k < 9; k++)
          a_prod[ch][k] <= $signed({1'b0, job.win[k][16 - ch*8 +: 8]})
                           * $signed(kernel[k/3][(k%3)*16 +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else if (!stall_b) begin
      if (b_valid && !b_done) b_phase <= 1'b1;
      else begin
        b_valid <= a_valid && (a_job.interior || a_job.border);
        b_phase <= 1'b0;
      end
    end
    if (!stall_b && b_done) begin
      b_job <= a_job;
      b_rgb <= filt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_ready || !res_valid) begin
      res_valid <= b_valid;
      if (b_valid) begin
        if (b_job.interior && !b_phase) begin
          res.rgb <= b_rgb;
          res.col <= b_job.col - 1'b1;
          res.row <= b_job.row - 1'b1;
          res.last <= !b_job.border;
        end else begin
          res.rgb <= b_job.px;
          res.col <= b_job.col;
          res.row <= b_job.row;
          res.last <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/c3rgb_checker.sv
// port-level checks for the convolution unit, bound to the top level
// uses only the top level's ports
module c3rgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  ap_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");
  ap_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[55])
    else $error("pad bit set");
  ap_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second result of a pair missing");
endmodule

bind conv3x3_rgb_border_passthrough_unit c3rgb_checker u_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast);

// File: tb/tb.sv
// self-checking testbench for conv3x3_rgb_border_passthrough_unit
// depends on c3rgb_pkg and the design files; holds its own frame predictor
module tb;
  typedef struct {
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [10:0] col;
    bit [15:0] row;
    bit        last;
  } filt_pix_t;

  class frame_scoreboard;
    bit [23:0]   older_line[2048];
    bit [23:0]   newer_line[2048];
    bit [23:0]   win[9];
    int unsigned col_cnt, row_cnt;
    bit [11:0]   fwidth;
    bit [15:0]   fheight;
    bit [47:0]   krow[3];
    filt_pix_t   due[$];
    int          errors;

    function new();
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      fwidth = 12'd640;
      fheight = 16'd480;
      krow[0] = '0;
      krow[1] = 48'd268435456;
      krow[2] = '0;
    endfunction

    function void write_reg(c3rgb_pkg::reg_idx_t idx, bit [47:0] v);
      case (idx)
        c3rgb_pkg::REG_WIDTH: begin
          fwidth = v[11:0];
          col_cnt = 0;
          row_cnt = 0;
        end
        c3rgb_pkg::REG_HEIGHT: begin
          fheight = v[15:0];
          col_cnt = 0;
          row_cnt = 0;
        end
        c3rgb_pkg::REG_KTOP: krow[0] = v;
        c3rgb_pkg::REG_KMID: krow[1] = v;
        c3rgb_pkg::REG_KBOT: krow[2] = v;
        default: ;
      endcase
    endfunction

    // correlation of one channel, rounded half away from zero, clamped
    function bit [7:0] filter_chan(int sh);
      longint acc;
      longint v;
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          acc += longint'(win[r*3+c][sh +: 8]) *
                 longint'($signed(krow[r][16*c +: 16]));
      if (acc <= 0) return 8'd0;
      v = (acc + (longint'(1) << 11)) >>> 12;
      return (v > longint'(c3rgb_pkg::CHAN_MAX)) ? 8'd255 : v[7:0];
    endfunction

    function void note_pixel(bit [7:0] r8, bit [7:0] g8, bit [7:0] b8);
      int unsigned w, h, c, r;
      bit [23:0]   px;
      filt_pix_t   res;
      int          n;
      w = (fwidth == 0) ? 1 : ((fwidth > c3rgb_pkg::MAX_WIDTH) ? c3rgb_pkg::MAX_WIDTH
                                                                 : int'(fwidth));
      h = (fheight == 0) ? 1 : int'(fheight);
      c = col_cnt;
      r = row_cnt;
      px = {r8, g8, b8};
      n = 0;
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = older_line[c];
      win[5] = newer_line[c];
      win[8] = px;
      older_line[c] = newer_line[c];
      newer_line[c] = px;
      if (c >= 2 && r >= 2) begin
        res.red = filter_chan(16);
        res.green = filter_chan(8);
        res.blue = filter_chan(0);
        res.col = 11'(c - 1);
        res.row = 16'(r - 1);
        res.last = 1'b0;
        due.push_back(res);
        n++;
      end
      if (r == 0 || c == 0 || r + 1 == h || c + 1 == w) begin
        res.red = r8;
        res.green = g8;
        res.blue = b8;
        res.col = 11'(c);
        res.row = 16'(r);
        res.last = 1'b0;
        due.push_back(res);
        n++;
      end
      if (n > 0) due[$].last = 1'b1;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_result(bit [55:0] d, bit tl);
      filt_pix_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat data=%h last=%b", d, tl);
        return;
      end
      e = due.pop_front();
      if (d[7:0] !== e.red || d[15:8] !== e.green || d[23:16] !== e.blue ||
          d[34:24] !== e.col || d[50:35] !== e.row || tl !== e.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch exp rgb=%h,%h,%h c=%0d r=%0d l=%b",
                    " got rgb=%h,%h,%h c=%0d r=%0d l=%b"},
                   e.red, e.green, e.blue, e.col, e.row, e.last,
                   d[7:0], d[15:8], d[23:16], d[34:24], d[50:35], tl);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // red, green, blue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // red, green, blue, column, row, zero pad
  logic        m_axis_tlast;       // last_of_run
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  frame_scoreboard sb = new();
  int  pixels_sent = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  conv3x3_rgb_border_passthrough_unit dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_pixel(bit [23:0] d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(d[7:0], d[15:8], d[23:16]);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_reg(c3rgb_pkg::reg_idx_t idx, bit [47:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic bit [47:0] pack_krow(bit [15:0] l, bit [15:0] m, bit [15:0] r);
    return {r, m, l};
  endfunction

  function automatic bit [23:0] rand_pixel();
    bit [23:0] p;
    p = 24'($urandom);
    if ($urandom_range(0, 7) == 0)
      for (int i = 0; i < 3; i++) p[8*i +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return p;
  endfunction

  function automatic bit [15:0] rand_coef();
    int v;
    v = $urandom_range(0, 16'h2800);
    return 16'(v - 16'h1400);
  endfunction

  function automatic bit [47:0] rand_krow();
    if ($urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
    return pack_krow(rand_coef(), rand_coef(), rand_coef());
  endfunction

  task automatic load_frame(bit [11:0] w, bit [15:0] h, bit [47:0] kt, bit [47:0] km,
                            bit [47:0] kb);
    settle();
    set_reg(c3rgb_pkg::REG_KTOP, kt);
    set_reg(c3rgb_pkg::REG_KMID, km);
    set_reg(c3rgb_pkg::REG_KBOT, kb);
    set_reg(c3rgb_pkg::REG_WIDTH, {36'd0, w});
    set_reg(c3rgb_pkg::REG_HEIGHT, {32'd0, h});
  endtask

  initial begin
    bit [47:0] ident;
    bit [47:0] kmax;
    bit [47:0] kmin;
    int        w, h, n, k;
    ident = pack_krow(16'h0000, 16'h1000, 16'h0000);
    kmax = pack_krow(16'h7fff, 16'h7fff, 16'h7fff);
    kmin = pack_krow(16'h8000, 16'h8000, 16'h8000);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings, first row: all border
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'haa55aa);
    // smallest frame with an interior pixel, under identity and both kernel extremes
    load_frame(12'd3, 16'd3, 48'd0, ident, 48'd0);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 24'hffffff : 24'h0055aa);
    load_frame(12'd3, 16'd3, kmax, kmax, kmax);
    for (int i = 0; i < 9; i++) send_pixel(24'(24'h010101 * i));
    load_frame(12'd3, 16'd3, kmin, kmin, kmin);
    for (int i = 0; i < 9; i++) send_pixel(24'hffffff);

    k = 0;
    while (pixels_sent < 1950) begin
      k++;
      if (pixels_sent > 1650) calm = 1'b1;
      case (k)
        3: begin w = 4095; h = 3; n = 24; end
        5: begin w = 0; h = 0; n = 6; end
        7: begin w = 5; h = 65535; n = 40; end
        9: begin w = 10; h = 8; n = 160; end
        default: begin
          w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
          h = $urandom_range(1, 7);
          n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
        end
      endcase
      load_frame(w[11:0], h[15:0], rand_krow(), rand_krow(), rand_krow());
      if (k == 9) hold_req = 1'b1;
      for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    end

    settle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
